// ===== sv/reprojection_error_accumulator_unit_macros.svh =====
// Assertion macros used by the reprojection error accumulator sequencer
`ifndef REPROJECTION_ERROR_ACCUMULATOR_UNIT_MACROS_SVH
`define REPROJECTION_ERROR_ACCUMULATOR_UNIT_MACROS_SVH

// implication checked every clock, quiet during reset
`define REA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, quiet during reset
`define REA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/rea_pkg.sv =====
// Types and constants of the reprojection error accumulator
package rea_pkg;
   localparam int COEFFS = 12;
   localparam int CATS = 4;
   localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [23:0] CNT_MAX = 24'hFF_FFFF;
   localparam logic [23:0] Q8_MAX = 24'hFF_FFFF;
   localparam logic KIND_LOAD = 1'b0;
   // ceil(2^28 / 3): exact floor division by three for sums below 2^27
   localparam logic [26:0] GR_RECIP = 27'h555_5556;

   typedef struct packed {
      logic        kind;
      logic [1:0]  view;
      logic [3:0]  coeff_index;
      logic signed [47:0] coeff_value;
      logic signed [31:0] world_x;
      logic signed [31:0] world_y;
      logic signed [31:0] world_z;
      logic [11:0] truth_x;
      logic [11:0] truth_y;
      logic [1:0]  category;
      logic        point_valid;
      logic        truth_valid;
   } req_type;

   typedef struct packed {
      logic [23:0] distance;
      logic [23:0] category_mean;
      logic [23:0] overall_mean;
      logic [23:0] grasper_mean;
      logic [23:0] category_total;
      logic        range_flag;
   } rsp_type;

   // datapath step commands
   localparam logic [3:0] OP_NONE  = 4'd0;
   localparam logic [3:0] OP_LOAD  = 4'd1;  // capture request
   localparam logic [3:0] OP_RD    = 4'd2;  // issue coefficient read
   localparam logic [3:0] OP_MUL   = 4'd3;  // multiply lo part
   localparam logic [3:0] OP_MULH  = 4'd4;  // multiply hi part and accumulate
   localparam logic [3:0] OP_DIVI  = 4'd5;  // start division
   localparam logic [3:0] OP_DIVS  = 4'd6;  // division step
   localparam logic [3:0] OP_DIVE  = 4'd7;  // division end
   localparam logic [3:0] OP_SQI   = 4'd8;
   localparam logic [3:0] OP_SQS   = 4'd9;
   localparam logic [3:0] OP_ACC   = 4'd10;
   localparam logic [3:0] OP_MNI   = 4'd11;
   localparam logic [3:0] OP_MNS   = 4'd12;
   localparam logic [3:0] OP_MNE   = 4'd13;
   localparam logic [3:0] OP_OUT   = 4'd14;

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] row;   // matrix row
      logic [1:0] col;   // matrix column
      logic       sel;   // which division
      logic [2:0] msel;  // mean index 0..4
   } cmd_type;

   typedef struct packed {
      logic step_done;   // current iterative unit finished
   } sts_type;
endpackage

// ===== sv/rea_ram.sv =====
// Generic single-port write, registered-read RAM
module rea_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== sv/rea_datapath.sv =====
// Datapath: coefficient store, projection MAC, divider, root, accumulators, means
module rea_datapath #(
   parameter int VIEWS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rea_pkg::req_type     req_in,
   input  rea_pkg::cmd_type     cmd,
   output rea_pkg::sts_type     sts,
   output logic                 meas_ok,
   output logic                 zero_div,
   output logic                 proj_sat,
   output rea_pkg::rsp_type     rsp_out
);
   import rea_pkg::*;
   localparam int AW = $clog2(VIEWS * COEFFS) > 0 ? $clog2(VIEWS * COEFFS) : 1;

   req_type r_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic signed [47:0] coef;
   logic [AW+3:0] wr_full, rd_full;
   logic load_ok;

   assign wr_full = ((AW+4)'(req_in.view) * (AW+4)'(COEFFS)) + (AW+4)'(req_in.coeff_index);
   assign wr_addr = wr_full[AW-1:0];
   assign rd_full = ((AW+4)'(r_ff.view) * (AW+4)'(COEFFS))
                  + (AW+4)'({cmd.row, cmd.col});
   assign rd_addr = rd_full[AW-1:0];
   assign load_ok = (32'(req_in.view) < VIEWS) && (req_in.coeff_index < 4'(COEFFS));
   assign meas_ok = req_in.point_valid && req_in.truth_valid && (32'(req_in.view) < VIEWS);

   rea_ram #(.WIDTH(48), .DEPTH(VIEWS * COEFFS)) u_coef (
      .clock  (clock),
      .wr_en  (cmd.op == OP_LOAD && req_in.kind == KIND_LOAD && load_ok),
      .wr_addr(wr_addr),
      .wr_data(req_in.coeff_value),
      .rd_addr(rd_addr),
      .rd_data(coef)
   );

   // ---- projection MAC: row sums in Q.18 ----
   logic signed [31:0] w_sel;
   logic signed [63:0] prod_lo_ff, prod_lo_in;
   logic signed [63:0] rows_ff [3];
   logic signed [63:0] rows_in [3];
   logic signed [63:0] term;
   logic signed [63:0] hi_prod;

   always_comb begin
      case (cmd.col)
         2'd0: w_sel = r_ff.world_x;
         2'd1: w_sel = r_ff.world_y;
         default: w_sel = r_ff.world_z;
      endcase
   end

   // c*lo (lo unsigned 16 bits) then c*hi + (c*lo >>> 16), floored >>> 2
   assign prod_lo_in = 64'(coef) * $signed({48'd0, w_sel[15:0]});
   assign hi_prod = 64'(coef) * 64'($signed(w_sel[31:16]));
   always_comb begin
      if (cmd.col == 2'd3) begin
         term = 64'(coef) >>> 2;
      end else begin
         term = (hi_prod + (prod_lo_ff >>> 16)) >>> 2;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) rows_in[i] = rows_ff[i];
      if (cmd.op == OP_LOAD) begin
         for (int i = 0; i < 3; i++) rows_in[i] = '0;
      end else if (cmd.op == OP_MULH) begin
         rows_in[cmd.row] = rows_ff[cmd.row] + term;
      end
   end

   // ---- divider, restoring, one bit per cycle ----
   logic [63:0] dnum_ff, dden_ff;
   logic [64:0] drem_ff;
   logic [71:0] dq_ff;
   logic [6:0]  dcnt_ff;
   logic        dneg_ff;
   logic signed [31:0] ux_ff, uy_ff;
   logic        psat_ff;
   logic [64:0] dtrial;
   logic [63:0] abs_n, abs_d;
   logic signed [63:0] num_sel;

   assign num_sel = cmd.sel ? rows_ff[1] : rows_ff[0];
   assign abs_n = num_sel[63] ? 64'(-num_sel) : num_sel;
   assign abs_d = rows_ff[2][63] ? 64'(-rows_ff[2]) : rows_ff[2];
   assign zero_div = (rows_ff[2] == '0);
   assign dtrial = {drem_ff[63:0], dnum_ff[63]} - {1'b0, dden_ff};

   // ---- square root, two bits per cycle ----
   logic [63:0] sq_v_ff, sq_res_ff, sq_bit_ff;
   logic [64:0] sq_sum;
   logic [25:0] adx, ady;
   assign sq_sum = {1'b0, sq_res_ff} + {1'b0, sq_bit_ff};

   // ---- accumulators ----
   logic [47:0] csum_ff [CATS];
   logic [23:0] ccnt_ff [CATS];
   logic [47:0] tsum_ff;
   logic [23:0] tcnt_ff;
   logic [23:0] dist_ff;
   logic        flag_ff;
   logic [48:0] csum_add, tsum_add;

   assign csum_add = {1'b0, csum_ff[r_ff.category]} + 49'(dist_ff);
   assign tsum_add = {1'b0, tsum_ff} + 49'(dist_ff);

   // ---- mean divider: 48 / 24 bits ----
   logic [47:0] mnum_ff;
   logic [23:0] mden_ff;
   logic [24:0] mrem_ff;
   logic [47:0] mq_ff;
   logic [5:0]  mcnt_ff;
   logic [23:0] means_ff [5];
   logic [25:0] msum;
   logic [52:0] gprod;
   logic [47:0] msel_sum;
   logic [23:0] msel_cnt;
   logic [25:0] mtrial;

   assign msum = 26'(means_ff[0]) + 26'(means_ff[1]) + 26'(means_ff[2]);
   // grasper mean: divide by three through a reciprocal multiply
   assign gprod = 53'(msum) * 53'(GR_RECIP);
   always_comb begin
      case (cmd.msel)
         3'd0, 3'd1, 3'd2, 3'd3: begin
            msel_sum = csum_ff[cmd.msel[1:0]];
            msel_cnt = ccnt_ff[cmd.msel[1:0]];
         end
         default: begin
            msel_sum = tsum_ff;
            msel_cnt = tcnt_ff;
         end
      endcase
   end
   assign mtrial = {mrem_ff, mnum_ff[47]} - {2'b0, mden_ff};

   always_comb begin
      sts.step_done = 1'b0;
      case (cmd.op)
         OP_DIVS: sts.step_done = (dcnt_ff == 7'd1);
         OP_SQS:  sts.step_done = (sq_bit_ff == '0);
         OP_MNS:  sts.step_done = (mcnt_ff == 6'd1);
         default: sts.step_done = 1'b0;
      endcase
   end
   assign proj_sat = psat_ff;

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         r_ff <= req_in;
         psat_ff <= 1'b0;
      end
      prod_lo_ff <= prod_lo_in;
      for (int i = 0; i < 3; i++) rows_ff[i] <= rows_in[i];

      case (cmd.op)
         OP_DIVI: begin
            dnum_ff <= abs_n;
            dden_ff <= abs_d;
            drem_ff <= '0;
            dq_ff <= '0;
            dcnt_ff <= 7'd72;
            dneg_ff <= num_sel[63] ^ rows_ff[2][63];
         end
         OP_DIVS: begin
            dnum_ff <= {dnum_ff[62:0], 1'b0};
            dcnt_ff <= dcnt_ff - 7'd1;
            if (!dtrial[64]) begin
               drem_ff <= dtrial;
               dq_ff <= {dq_ff[70:0], 1'b1};
            end else begin
               drem_ff <= {drem_ff[63:0], dnum_ff[63]};
               dq_ff <= {dq_ff[70:0], 1'b0};
            end
         end
         OP_DIVE: begin
            if (dq_ff[71:8] >= 64'd131072) begin
               psat_ff <= 1'b1;
            end
            if (cmd.sel) begin
               uy_ff <= dneg_ff ? -$signed({7'd0, dq_ff[24:0]}) : $signed({7'd0, dq_ff[24:0]});
            end else begin
               ux_ff <= dneg_ff ? -$signed({7'd0, dq_ff[24:0]}) : $signed({7'd0, dq_ff[24:0]});
            end
         end
         OP_SQI: begin
            sq_v_ff <= 64'(52'(adx) * 52'(adx)) + 64'(52'(ady) * 52'(ady));
            sq_res_ff <= '0;
            sq_bit_ff <= 64'h4000_0000_0000_0000;
         end
         OP_SQS: begin
            if (sq_bit_ff != '0) begin
               if (sq_v_ff >= sq_sum[63:0] && !sq_sum[64]) begin
                  sq_v_ff <= sq_v_ff - sq_sum[63:0];
                  sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_res_ff <= sq_res_ff >> 1;
               end
               sq_bit_ff <= sq_bit_ff >> 2;
            end
         end
         OP_MNI: begin
            mnum_ff <= msel_sum;
            mden_ff <= msel_cnt;
            mrem_ff <= '0;
            mq_ff <= '0;
            mcnt_ff <= 6'd48;
         end
         OP_MNS: begin
            mnum_ff <= {mnum_ff[46:0], 1'b0};
            mcnt_ff <= mcnt_ff - 6'd1;
            if (!mtrial[25]) begin
               mrem_ff <= mtrial[24:0];
               mq_ff <= {mq_ff[46:0], 1'b1};
            end else begin
               mrem_ff <= {mrem_ff[23:0], mnum_ff[47]};
               mq_ff <= {mq_ff[46:0], 1'b0};
            end
         end
         OP_MNE: begin
            if (mden_ff == '0) begin
               means_ff[cmd.msel] <= '0;
            end else if (mq_ff > 48'(Q8_MAX)) begin
               means_ff[cmd.msel] <= Q8_MAX;
            end else begin
               means_ff[cmd.msel] <= mq_ff[23:0];
            end
         end
         default: ;
      endcase

      // distance capture
      if (cmd.op == OP_DIVI && !cmd.sel) begin
         dist_ff <= Q8_MAX;
         flag_ff <= zero_div;
      end else if (cmd.op == OP_SQS && sq_bit_ff == '0) begin
         if (sq_res_ff > 64'(Q8_MAX)) begin
            dist_ff <= Q8_MAX;
            flag_ff <= 1'b1;
         end else begin
            dist_ff <= sq_res_ff[23:0];
            flag_ff <= 1'b0;
         end
      end else if (cmd.op == OP_DIVE && cmd.sel && (psat_ff || dq_ff[71:8] >= 64'd131072)) begin
         dist_ff <= Q8_MAX;
         flag_ff <= 1'b1;
      end
   end

   always_comb begin
      logic signed [33:0] dx, dy;
      dx = 34'($signed({1'b0, r_ff.truth_x, 8'd0})) - 34'(ux_ff);
      dy = 34'($signed({1'b0, r_ff.truth_y, 8'd0})) - 34'(uy_ff);
      adx = dx[33] ? 26'(-dx) : dx[25:0];
      ady = dy[33] ? 26'(-dy) : dy[25:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CATS; i++) begin
            csum_ff[i] <= '0;
            ccnt_ff[i] <= '0;
         end
         tsum_ff <= '0;
         tcnt_ff <= '0;
      end else if (cmd.op == OP_ACC) begin
         csum_ff[r_ff.category] <= csum_add[48] ? SUM_MAX : csum_add[47:0];
         tsum_ff <= tsum_add[48] ? SUM_MAX : tsum_add[47:0];
         if (ccnt_ff[r_ff.category] != CNT_MAX) begin
            ccnt_ff[r_ff.category] <= ccnt_ff[r_ff.category] + 24'd1;
         end
         if (tcnt_ff != CNT_MAX) begin
            tcnt_ff <= tcnt_ff + 24'd1;
         end
      end
   end

   always_comb begin
      rsp_out.distance = dist_ff;
      rsp_out.category_mean = means_ff[r_ff.category == 2'd3 ? 3'd3 : 3'(r_ff.category)];
      rsp_out.overall_mean = means_ff[4];
      rsp_out.grasper_mean = gprod[51:28];
      rsp_out.category_total = ccnt_ff[r_ff.category];
      rsp_out.range_flag = flag_ff;
   end
endmodule

// ===== sv/rea_ctrl.sv =====
// Sequencer: steps the datapath through projection, division, root and means
module rea_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_kind,
   input  logic             meas_ok,
   input  logic             zero_div,
   input  logic             proj_sat,
   input  rea_pkg::sts_type sts,
   output rea_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready
);
   import rea_pkg::*;
   `include "reprojection_error_accumulator_unit_macros.svh"

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RD   = 4'd1;
   localparam logic [3:0] S_LO   = 4'd2;
   localparam logic [3:0] S_HI   = 4'd3;
   localparam logic [3:0] S_DI   = 4'd4;
   localparam logic [3:0] S_DS   = 4'd5;
   localparam logic [3:0] S_DE   = 4'd6;
   localparam logic [3:0] S_SI   = 4'd7;
   localparam logic [3:0] S_SS   = 4'd8;
   localparam logic [3:0] S_ACC  = 4'd9;
   localparam logic [3:0] S_MI   = 4'd10;
   localparam logic [3:0] S_MS   = 4'd11;
   localparam logic [3:0] S_ME   = 4'd12;
   localparam logic [3:0] S_OUT  = 4'd13;

   logic [3:0] state_ff, state_in;
   logic [1:0] row_ff, row_in, col_ff, col_in;
   logic       sel_ff, sel_in;
   logic [2:0] msel_ff, msel_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept = req_valid && req_ready;
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      col_in = col_ff;
      sel_in = sel_ff;
      msel_in = msel_ff;
      cmd = '{op: OP_NONE, row: row_ff, col: col_ff, sel: sel_ff, msel: msel_ff};
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.op = OP_LOAD;
               if (req_kind != KIND_LOAD && meas_ok) begin
                  state_in = S_RD;
                  row_in = 2'd0;
                  col_in = 2'd0;
               end
            end
         end
         S_RD: begin
            cmd.op = OP_RD;
            state_in = S_LO;
         end
         S_LO: begin
            cmd.op = OP_MUL;
            state_in = S_HI;
         end
         S_HI: begin
            cmd.op = OP_MULH;
            state_in = S_RD;
            col_in = col_ff + 2'd1;
            if (col_ff == 2'd3) begin
               row_in = row_ff + 2'd1;
               if (row_ff == 2'd2) begin
                  state_in = S_DI;
                  sel_in = 1'b0;
               end
            end
         end
         S_DI: begin
            cmd.op = OP_DIVI;
            state_in = zero_div ? S_ACC : S_DS;
         end
         S_DS: begin
            cmd.op = OP_DIVS;
            if (sts.step_done) state_in = S_DE;
         end
         S_DE: begin
            cmd.op = OP_DIVE;
            if (sel_ff) begin
               state_in = S_SI;
            end else begin
               sel_in = 1'b1;
               state_in = S_DI;
            end
         end
         S_SI: begin
            cmd.op = OP_SQI;
            state_in = proj_sat ? S_ACC : S_SS;
         end
         S_SS: begin
            cmd.op = OP_SQS;
            if (sts.step_done) state_in = S_ACC;
         end
         S_ACC: begin
            cmd.op = OP_ACC;
            msel_in = 3'd0;
            state_in = S_MI;
         end
         S_MI: begin
            cmd.op = OP_MNI;
            state_in = S_MS;
         end
         S_MS: begin
            cmd.op = OP_MNS;
            if (sts.step_done) state_in = S_ME;
         end
         S_ME: begin
            cmd.op = OP_MNE;
            // four category means, then the overall mean
            if (msel_ff == 3'd4) begin
               state_in = S_OUT;
            end else begin
               msel_in = msel_ff + 3'd1;
               state_in = S_MI;
            end
         end
         S_OUT: begin
            cmd.op = OP_OUT;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_ff <= '0;
         col_ff <= '0;
         sel_ff <= 1'b0;
         msel_ff <= '0;
      end else begin
         state_ff <= state_in;
         row_ff <= row_in;
         col_ff <= col_in;
         sel_ff <= sel_in;
         msel_ff <= msel_in;
      end
   end

   `REA_ASSERT_IMPLY(a_ready_idle, clock, reset, rsp_valid, !req_ready)
   `REA_ASSERT_NEXT(a_acc_to_mean, clock, reset, state_ff == S_ACC, state_ff == S_MI)
   `REA_ASSERT_NEXT(a_out_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule

// ===== sv/reprojection_error_accumulator_unit.sv =====
// Reprojection error accumulator: coefficient loads and per-measurement error statistics.
// One request at a time. A load is accepted and the block is ready again the next cycle.
// A valid measurement holds the block through these steps: the accept, the projection
// (twelve coefficient reads, each with a low and a high multiply step), two restoring
// divisions (72 steps plus start and end), a square root, an accumulate step, five
// mean divisions and the output. The dividers produce one quotient bit per cycle. A
// zero divisor skips the divisions and root; a projection too large skips the root.
// The grasper mean uses a reciprocal multiply. The response is held until it is taken.
module reprojection_error_accumulator_unit #(
   parameter int VIEWS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rea_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rea_pkg::rsp_type rsp_data
);
   import rea_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic meas_ok, zero_div, proj_sat;

   rea_datapath #(.VIEWS(VIEWS)) u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_data),
      .cmd     (cmd),
      .sts     (sts),
      .meas_ok (meas_ok),
      .zero_div(zero_div),
      .proj_sat(proj_sat),
      .rsp_out (rsp_data)
   );

   rea_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind (req_data.kind),
      .meas_ok  (meas_ok),
      .zero_div (zero_div),
      .proj_sat (proj_sat),
      .sts      (sts),
      .cmd      (cmd),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready)
   );
endmodule
